[rtl/quick_mask_edge_filter_3x3_assert.svh]
// Assertion macros used by the filter RTL.
// The clock is clk_i and the active-low reset is rst_ni in every user.
`ifndef QUICK_MASK_EDGE_FILTER_3X3_ASSERT_SVH
`define QUICK_MASK_EDGE_FILTER_3X3_ASSERT_SVH

// Same-cycle implication.
`define QMEF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QMEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/qmef_pkg.sv]
`default_nettype none

package qmef_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned FW_W   = 11;
  localparam int unsigned FH_W   = 13;
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET    = 11'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RESET   = 13'd480;
  localparam logic [PIX_W-1:0] EDGE_THRESHOLD_RESET = 8'd128;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } reg_idx_e;

  // Position information of one pixel, produced by the raster counters.
  typedef struct packed {
    logic             emit;
    logic             frame_last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_info_t;

endpackage

`default_nettype wire

[rtl/qmef_line_ram.sv]
`default_nettype none

module qmef_line_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [qmef_pkg::PIX_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [qmef_pkg::PIX_W-1:0]  rdata_o
);

  logic [qmef_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [qmef_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/qmef_ctrl.sv]
`default_nettype none

module qmef_ctrl #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned CW         = $clog2(MAX_WIDTH)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [qmef_pkg::FW_W-1:0]  frame_width_i,
  input  wire logic [qmef_pkg::FH_W-1:0]  frame_height_i,
  output logic      [CW-1:0]              addr_o,
  output qmef_pkg::pos_info_t             info_o
);

  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned HCW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  logic           row_end;
  logic           frame_end;
  logic [31:0]    row_m1;
  logic [31:0]    col_m1;

  // Out-of-range sizes saturate to 3 below and to the maximum above.
  always_comb begin
    if (frame_width_i < qmef_pkg::FW_W'(3)) begin
      w_eff = WCW'(3);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(frame_width_i);
    end
    if (frame_height_i < qmef_pkg::FH_W'(3)) begin
      h_eff = HCW'(3);
    end else if (32'(frame_height_i) > 32'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(frame_height_i);
    end
  end

  assign row_end   = (WCW'(col_q) + WCW'(1)) >= w_eff;
  assign frame_end = row_end && ((HCW'(row_q) + HCW'(1)) >= h_eff);
  assign row_m1    = 32'(row_q) - 32'd1;
  assign col_m1    = 32'(col_q) - 32'd1;

  always_comb begin
    info_o.emit       = (col_q >= CW'(2)) && (row_q >= RW'(2));
    info_o.frame_last = frame_end;
    info_o.row        = row_m1[qmef_pkg::ROW_W-1:0];
    info_o.col        = col_m1[qmef_pkg::COL_W-1:0];
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign addr_o = col_q;

endmodule

`default_nettype wire

[rtl/qmef_window.sv]
`default_nettype none

module qmef_window (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       shift_i,
  input  wire logic [qmef_pkg::PIX_W-1:0] up_i,
  input  wire logic [qmef_pkg::PIX_W-1:0] mid_i,
  input  wire logic [qmef_pkg::PIX_W-1:0] pix_i,
  input  wire logic [qmef_pkg::PIX_W-1:0] threshold_i,
  output logic      [qmef_pkg::PIX_W-1:0] strength_o,
  output logic                            edge_flag_o
);

  // Rows 0..2 top to bottom, column 2 holds the newest pixel of each row.
  logic [qmef_pkg::PIX_W-1:0] win_q [9];
  logic signed [10:0]         sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]     <= win_q[k*3 + 1];
        win_q[k*3 + 1] <= win_q[k*3 + 2];
      end
      win_q[2] <= up_i;
      win_q[5] <= mid_i;
      win_q[8] <= pix_i;
    end
  end

  // The response is taken on the window as it looks after this shift, so the
  // center comes from column 2 and the left diagonals from column 1 of the old window.
  always_comb begin
    sum = $signed({1'b0, win_q[5], 2'b00})
        - $signed({3'b000, win_q[1]})
        - $signed({3'b000, up_i})
        - $signed({3'b000, win_q[7]})
        - $signed({3'b000, pix_i});
    if (sum < 11'sd0) begin
      strength_o = '0;
    end else if (sum > 11'sd255) begin
      strength_o = 8'd255;
    end else begin
      strength_o = sum[7:0];
    end
  end

  assign edge_flag_o = strength_o >= threshold_i;

endmodule

`default_nettype wire

[rtl/quick_mask_edge_filter_3x3.sv]
// A pixel transaction is registered in stage 1 when it is accepted, and its result is
// registered in the output register when it leaves stage 1. Throughput: one pixel per cycle;
// each line store takes one read and one write per cycle, and back pressure only holds the
// input while a result is waiting. Reset clears the raster counters, the window and all valid
// flags, and loads the default frame size and threshold. The line stores are not cleared.
`default_nettype none

`include "quick_mask_edge_filter_3x3_assert.svh"

module quick_mask_edge_filter_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [qmef_pkg::PIX_W-1:0]   gray_pixel_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [qmef_pkg::PIX_W-1:0]   strength_o,
  output logic                              edge_flag_o,
  output logic      [qmef_pkg::ROW_W-1:0]   out_row_o,
  output logic      [qmef_pkg::COL_W-1:0]   out_col_o,
  output logic                              frame_last_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [qmef_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [qmef_pkg::CFG_DW-1:0]  pwdata,
  output logic      [qmef_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [qmef_pkg::FW_W-1:0]  frame_width_q;
  logic [qmef_pkg::FH_W-1:0]  frame_height_q;
  logic [qmef_pkg::PIX_W-1:0] edge_threshold_q;
  qmef_pkg::reg_idx_e         reg_idx;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = qmef_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= qmef_pkg::FRAME_WIDTH_RESET;
      frame_height_q   <= qmef_pkg::FRAME_HEIGHT_RESET;
      edge_threshold_q <= qmef_pkg::EDGE_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        qmef_pkg::REG_FRAME_WIDTH:    frame_width_q    <= pwdata[qmef_pkg::FW_W-1:0];
        qmef_pkg::REG_FRAME_HEIGHT:   frame_height_q   <= pwdata[qmef_pkg::FH_W-1:0];
        qmef_pkg::REG_EDGE_THRESHOLD: edge_threshold_q <= pwdata[qmef_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qmef_pkg::REG_FRAME_WIDTH:    prdata = qmef_pkg::CFG_DW'(frame_width_q);
      qmef_pkg::REG_FRAME_HEIGHT:   prdata = qmef_pkg::CFG_DW'(frame_height_q);
      qmef_pkg::REG_EDGE_THRESHOLD: prdata = qmef_pkg::CFG_DW'(edge_threshold_q);
      default:                      prdata = '0;
    endcase
  end

  // Pipeline control. Stage 1 holds the pixel while the line stores answer.
  logic                       advance;
  logic                       accept;
  logic                       s1_leave;
  logic                       out_blocked;
  logic                       s1_valid_q;
  logic [qmef_pkg::PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]              s1_addr_q;
  qmef_pkg::pos_info_t        s1_info_q;
  logic [CW-1:0]              rd_addr;
  qmef_pkg::pos_info_t        rd_info;
  logic [qmef_pkg::PIX_W-1:0] up_data;
  logic [qmef_pkg::PIX_W-1:0] mid_data;
  logic [qmef_pkg::PIX_W-1:0] win_strength;
  logic                       win_edge;

  // Stage 1 drains unless it carries a result and the output register is full
  // and stalled.
  assign out_blocked = out_valid_o && out_stall_i;
  assign advance     = !s1_valid_q || !s1_info_q.emit || !out_blocked;
  assign accept      = in_valid_i && advance;
  assign s1_leave    = s1_valid_q && advance;
  assign in_stall_o  = !advance;

  qmef_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .addr_o         (rd_addr),
    .info_o         (rd_info)
  );

  // Consecutive pixels never touch the same column, so the write-back of the
  // leaving pixel cannot collide with the read of the entering one.
  qmef_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (s1_leave),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (up_data)
  );

  qmef_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (s1_leave),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (mid_data)
  );

  qmef_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_leave),
    .up_i        (up_data),
    .mid_i       (mid_data),
    .pix_i       (s1_pix_q),
    .threshold_i (edge_threshold_q),
    .strength_o  (win_strength),
    .edge_flag_o (win_edge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= gray_pixel_i;
      s1_addr_q <= rd_addr;
      s1_info_q <= rd_info;
    end
  end

  // Output register.
  logic out_valid_q;
  logic out_load;

  assign out_load = s1_leave && s1_info_q.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      strength_o   <= win_strength;
      edge_flag_o  <= win_edge;
      out_row_o    <= s1_info_q.row;
      out_col_o    <= s1_info_q.col;
      frame_last_o <= s1_info_q.frame_last;
    end
  end

  assign out_valid_o = out_valid_q;

  `QMEF_ASSERT_IMPLIES(a_empty_stage_no_stall, !s1_valid_q, !in_stall_o, "stall while empty")
  `QMEF_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid_q, "accepted pixel lost")
  `QMEF_ASSERT_IMPLIES(a_stall_has_cause, in_stall_o, s1_valid_q && out_blocked, "no stall cause")

endmodule

`default_nettype wire
